// File: rtl/core/lbc_pkg.sv
// Package for the LRU block buffer cache: field widths, codes and the
// structs shared between the cells, the controller and the top level.
// No dependencies.
`default_nettype none

package lbc_pkg;

    localparam int DEV_W = 8;
    localparam int BLK_W = 32;
    localparam int IDX_W = 5;
    localparam int CNT_W = 8;

    localparam logic [CNT_W-1:0] COUNT_MAX = 8'hFF;

    typedef enum logic [1:0] {
        ACT_READ    = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_PIN     = 2'd2,
        ACT_UNPIN   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOFREE = 2'd1,
        ST_UNDER  = 2'd2,
        ST_SAT    = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_PICK = 1'b1
    } state_t;

    // Contents of one buffer entry, apart from its entry number.
    typedef struct packed {
        logic [DEV_W-1:0] dev;
        logic [BLK_W-1:0] blk;
        logic             valid;
        logic [CNT_W-1:0] count;
    } entry_t;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        logic capture;
        logic write;
        logic shift;
    } cell_cmd_t;

    // Per-cell compare results, registered when a request is captured.
    typedef struct packed {
        logic hit;
        logic idm;
        logic free;
    } cell_flag_t;

    // One result item.
    typedef struct packed {
        logic [IDX_W-1:0] granted_entry;
        logic             was_hit;
        logic             fill_needed;
        logic [1:0]       status;
    } rsp_t;

endpackage

`default_nettype wire

// File: rtl/core/lbc_req_if.sv
// Request channel of the LRU block buffer cache: valid, ready and payload.
// Depends on lbc_pkg for the field widths.
`default_nettype none

interface lbc_req_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  action;
    logic [lbc_pkg::DEV_W-1:0]   device;
    logic [lbc_pkg::BLK_W-1:0]   block_number;
    logic [lbc_pkg::IDX_W-1:0]   entry_index;

    modport source (output valid, output action, output device, output block_number,
                    output entry_index, input ready);
    modport sink   (input valid, input action, input device, input block_number,
                    input entry_index, output ready);
endinterface

`default_nettype wire

// File: rtl/core/lbc_rsp_if.sv
// Result channel of the LRU block buffer cache: valid, ready and payload.
// Depends on lbc_pkg for the field widths.
`default_nettype none

interface lbc_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [lbc_pkg::IDX_W-1:0]   granted_entry;
    logic                        was_hit;
    logic                        fill_needed;
    logic [1:0]                  status;

    modport source (output valid, output granted_entry, output was_hit,
                    output fill_needed, output status, input ready);
    modport sink   (input valid, input granted_entry, input was_hit,
                    input fill_needed, input status, output ready);
endinterface

`default_nettype wire

// File: rtl/core/lru_block_buffer_cache.sv
// Top level of the LRU block buffer cache: a row of recency cells and the
// controller that picks and updates one cell per request.
// Depends on lbc_pkg, lbc_req_if, lbc_rsp_if, lbc_cell and lbc_ctrl.
//
//   Channel  Direction  Payload
//   req      in         action, device, block_number, entry_index
//   rsp      out        granted_entry, was_hit, fill_needed, status
//
// For each request the cells first register the tag, entry-number and
// free compares, then the controller does the priority pick and the update.
// The update cycle waits while a previous result is still held in the
// result register; a new request is taken once the update is done.
// Reset is asynchronous and puts every cell at its initial contents at once.
// A release that frees an entry moves it to the front in that same cycle.
`default_nettype none

module lru_block_buffer_cache #(
    parameter int ENTRIES = 32
) (
    input  wire       clk,
    input  wire       rst_n,
    lbc_req_if.sink   req,
    lbc_rsp_if.source rsp
);

    localparam int IW = $clog2(ENTRIES);

    lbc_pkg::entry_t     cell_ent  [ENTRIES];
    logic [IW-1:0]       cell_id   [ENTRIES];
    lbc_pkg::cell_flag_t cell_flag [ENTRIES];
    lbc_pkg::cell_cmd_t  cmd;
    logic [IW-1:0]       sel;
    lbc_pkg::entry_t     new_ent;
    logic [IW-1:0]       new_id;
    lbc_pkg::rsp_t       out_rsp;
    logic                out_valid;

    lbc_ctrl #(
        .ENTRIES (ENTRIES),
        .IW      (IW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .in_action (req.action),
        .in_dev    (req.device),
        .in_blk    (req.block_number),
        .in_idx    (req.entry_index),
        .cell_ent  (cell_ent),
        .cell_id   (cell_id),
        .cell_flag (cell_flag),
        .cmd       (cmd),
        .sel       (sel),
        .new_ent   (new_ent),
        .new_id    (new_id),
        .out_valid (out_valid),
        .out_ready (rsp.ready),
        .out_rsp   (out_rsp)
    );

    // Position zero is the most recent; each cell takes from the one before.
    for (genvar p = 0; p < ENTRIES; p++)
    begin : g_cell
        lbc_pkg::entry_t left_ent;
        logic [IW-1:0]   left_id;

        if (p == 0)
        begin : g_front
            assign left_ent = new_ent;
            assign left_id  = new_id;
        end
        else
        begin : g_rest
            assign left_ent = cell_ent[p-1];
            assign left_id  = cell_id[p-1];
        end

        lbc_cell #(
            .IW     (IW),
            .POS    (IW'(p)),
            .RST_ID (IW'(ENTRIES - 1 - p))
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .sel      (sel),
            .new_ent  (new_ent),
            .new_id   (new_id),
            .left_ent (left_ent),
            .left_id  (left_id),
            .dev      (req.device),
            .blk      (req.block_number),
            .idx      (req.entry_index),
            .ent      (cell_ent[p]),
            .id       (cell_id[p]),
            .flag     (cell_flag[p])
        );
    end

    assign rsp.valid         = out_valid;
    assign rsp.granted_entry = out_rsp.granted_entry;
    assign rsp.was_hit       = out_rsp.was_hit;
    assign rsp.fill_needed   = out_rsp.fill_needed;
    assign rsp.status        = out_rsp.status;

`ifndef SYNTHESIS
    // A request in flight blocks the next one.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request accepted while another was in flight");

    // A new result only appears right after an update cycle.
    a_result_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(!req.ready))
        else $error("result raised without a pending request");

    // Cells never see a write and a shift together, nor either during capture.
    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.write || cmd.shift) |-> (!(cmd.write && cmd.shift) && !cmd.capture))
        else $error("conflicting cell commands");

    // A shift only follows a successful release.
    a_shift_ok: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift |=> (rsp.valid && (rsp.status == lbc_pkg::ST_OK) && !rsp.was_hit))
        else $error("entry moved without a successful release");
`endif

endmodule

`default_nettype wire

// File: rtl/core/lbc_cell.sv
// One recency position of the buffer cache: holds an entry and its number,
// compares it against a captured request and takes data from its neighbor.
// Depends on lbc_pkg.
`default_nettype none

module lbc_cell #(
    parameter int             IW     = 5,
    parameter logic [IW-1:0]  POS    = '0,
    parameter logic [IW-1:0]  RST_ID = '0
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire  lbc_pkg::cell_cmd_t         cmd,
    input  wire  [IW-1:0]                    sel,
    input  wire  lbc_pkg::entry_t            new_ent,
    input  wire  [IW-1:0]                    new_id,
    input  wire  lbc_pkg::entry_t            left_ent,
    input  wire  [IW-1:0]                    left_id,
    input  wire  [lbc_pkg::DEV_W-1:0]        dev,
    input  wire  [lbc_pkg::BLK_W-1:0]        blk,
    input  wire  [lbc_pkg::IDX_W-1:0]        idx,
    output lbc_pkg::entry_t                  ent,
    output logic [IW-1:0]                    id,
    output lbc_pkg::cell_flag_t              flag
);

    localparam int CW = (IW > lbc_pkg::IDX_W) ? IW : lbc_pkg::IDX_W;

    lbc_pkg::entry_t     ent_reg, ent_next;
    logic [IW-1:0]       id_reg, id_next;
    lbc_pkg::cell_flag_t flag_reg, flag_next;
    logic [CW-1:0]       id_x, idx_x;
    logic                take_new, take_left;

    assign id_x  = CW'(id_reg);
    assign idx_x = CW'(idx);

    // A shift moves every position up to the selected one back by one place,
    // with the updated entry entering at the front.
    assign take_new  = (cmd.shift && (POS == '0)) || (cmd.write && (sel == POS));
    assign take_left = cmd.shift && (POS != '0) && (POS <= sel);

    always_comb
    begin
        ent_next  = ent_reg;
        id_next   = id_reg;
        flag_next = flag_reg;
        if (take_new)
        begin
            ent_next = new_ent;
            id_next  = new_id;
        end
        else if (take_left)
        begin
            ent_next = left_ent;
            id_next  = left_id;
        end
        // Compare against the incoming request while the state is settled.
        if (cmd.capture)
        begin
            flag_next.hit  = (ent_reg.dev == dev) && (ent_reg.blk == blk);
            flag_next.idm  = (id_x == idx_x);
            flag_next.free = (ent_reg.count == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_reg  <= '0;
            id_reg   <= RST_ID;
            flag_reg <= '0;
        end
        else
        begin
            ent_reg  <= ent_next;
            id_reg   <= id_next;
            flag_reg <= flag_next;
        end
    end

    assign ent  = ent_reg;
    assign id   = id_reg;
    assign flag = flag_reg;

endmodule

`default_nettype wire

// File: rtl/core/lbc_ctrl.sv
// Controller of the buffer cache: request capture, priority pick over the
// cell flags, entry update, cell commands and the result register.
// Depends on lbc_pkg.
`default_nettype none

module lbc_ctrl #(
    parameter int ENTRIES = 32,
    parameter int IW      = 5
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           in_valid,
    output logic                          in_ready,
    input  wire  [1:0]                    in_action,
    input  wire  [lbc_pkg::DEV_W-1:0]     in_dev,
    input  wire  [lbc_pkg::BLK_W-1:0]     in_blk,
    input  wire  [lbc_pkg::IDX_W-1:0]     in_idx,
    input  wire  lbc_pkg::entry_t         cell_ent  [ENTRIES],
    input  wire  [IW-1:0]                 cell_id   [ENTRIES],
    input  wire  lbc_pkg::cell_flag_t     cell_flag [ENTRIES],
    output lbc_pkg::cell_cmd_t            cmd,
    output logic [IW-1:0]                 sel,
    output lbc_pkg::entry_t               new_ent,
    output logic [IW-1:0]                 new_id,
    output logic                          out_valid,
    input  wire                           out_ready,
    output lbc_pkg::rsp_t                 out_rsp
);

    localparam int CW = (IW > lbc_pkg::IDX_W) ? IW : lbc_pkg::IDX_W;

    lbc_pkg::state_t           state_reg, state_next;
    logic [1:0]                action_reg, action_next;
    logic [lbc_pkg::DEV_W-1:0] dev_reg, dev_next;
    logic [lbc_pkg::BLK_W-1:0] blk_reg, blk_next;
    logic [lbc_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic                      out_valid_reg, out_valid_next;
    lbc_pkg::rsp_t             rsp_reg, rsp_next;

    logic                      hit_any, free_any, id_any;
    logic [IW-1:0]             hit_pos, free_pos, id_pos;
    lbc_pkg::entry_t           cur;
    logic [IW-1:0]             cur_id;
    logic [CW-1:0]             cur_id_x;
    logic                      commit, accept;
    logic                      do_write, do_shift;
    lbc_pkg::rsp_t             res;

    assign in_ready = (state_reg == lbc_pkg::S_IDLE);
    assign accept   = in_valid && in_ready;
    assign commit   = (state_reg == lbc_pkg::S_PICK) && (!out_valid_reg || out_ready);

    // Priority pick: first hit from the front, first free entry from the back.
    always_comb
    begin
        hit_any  = 1'b0;
        free_any = 1'b0;
        id_any   = 1'b0;
        hit_pos  = '0;
        free_pos = '0;
        id_pos   = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (cell_flag[i].hit)
            begin
                hit_any = 1'b1;
                hit_pos = IW'(i);
            end
        end
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (cell_flag[i].free)
            begin
                free_any = 1'b1;
                free_pos = IW'(i);
            end
            if (cell_flag[i].idm)
            begin
                id_any = 1'b1;
                id_pos = IW'(i);
            end
        end
    end

    // Position chosen for the request, and that position's contents.
    always_comb
    begin
        if (lbc_pkg::action_t'(action_reg) == lbc_pkg::ACT_READ)
        begin
            sel = hit_any ? hit_pos : free_pos;
        end
        else
        begin
            sel = id_pos;
        end
    end

    assign cur      = cell_ent[sel];
    assign cur_id   = cell_id[sel];
    assign cur_id_x = CW'(cur_id);

    // Entry update and result for the captured request.
    always_comb
    begin
        new_ent           = cur;
        new_id            = cur_id;
        do_write          = 1'b0;
        do_shift          = 1'b0;
        res.granted_entry = idx_reg;
        res.was_hit       = 1'b0;
        res.fill_needed   = 1'b0;
        res.status        = lbc_pkg::ST_OK;
        case (lbc_pkg::action_t'(action_reg))
            lbc_pkg::ACT_READ:
            begin
                res.granted_entry = '0;
                if (hit_any)
                begin
                    res.granted_entry = cur_id_x[lbc_pkg::IDX_W-1:0];
                    res.was_hit       = 1'b1;
                    if (cur.count == lbc_pkg::COUNT_MAX)
                    begin
                        res.status = lbc_pkg::ST_SAT;
                    end
                    else
                    begin
                        new_ent.count   = cur.count + 1'b1;
                        new_ent.valid   = 1'b1;
                        res.fill_needed = !cur.valid;
                        do_write        = 1'b1;
                    end
                end
                else if (free_any)
                begin
                    res.granted_entry = cur_id_x[lbc_pkg::IDX_W-1:0];
                    res.fill_needed   = 1'b1;
                    new_ent.dev       = dev_reg;
                    new_ent.blk       = blk_reg;
                    new_ent.valid     = 1'b1;
                    new_ent.count     = lbc_pkg::CNT_W'(1);
                    do_write          = 1'b1;
                end
                else
                begin
                    res.status = lbc_pkg::ST_NOFREE;
                end
            end
            lbc_pkg::ACT_PIN:
            begin
                if (id_any)
                begin
                    if (cur.count == lbc_pkg::COUNT_MAX)
                    begin
                        res.status = lbc_pkg::ST_SAT;
                    end
                    else
                    begin
                        new_ent.count = cur.count + 1'b1;
                        do_write      = 1'b1;
                    end
                end
            end
            lbc_pkg::ACT_RELEASE, lbc_pkg::ACT_UNPIN:
            begin
                if (id_any)
                begin
                    if (cur.count == '0)
                    begin
                        res.status = lbc_pkg::ST_UNDER;
                    end
                    else
                    begin
                        new_ent.count = cur.count - 1'b1;
                        // A release that frees the entry makes it most recent.
                        if ((lbc_pkg::action_t'(action_reg) == lbc_pkg::ACT_RELEASE)
                            && (cur.count == lbc_pkg::CNT_W'(1)))
                        begin
                            do_shift = 1'b1;
                        end
                        else
                        begin
                            do_write = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                res.status = lbc_pkg::ST_OK;
            end
        endcase
    end

    assign cmd.capture = accept;
    assign cmd.write   = commit && do_write;
    assign cmd.shift   = commit && do_shift;

    // Next state, request capture and result register.
    always_comb
    begin
        state_next     = state_reg;
        action_next    = action_reg;
        dev_next       = dev_reg;
        blk_next       = blk_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        rsp_next       = rsp_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            lbc_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    action_next = in_action;
                    dev_next    = in_dev;
                    blk_next    = in_blk;
                    idx_next    = in_idx;
                    state_next  = lbc_pkg::S_PICK;
                end
            end
            lbc_pkg::S_PICK:
            begin
                if (commit)
                begin
                    rsp_next       = res;
                    out_valid_next = 1'b1;
                    state_next     = lbc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lbc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lbc_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg <= action_next;
        dev_reg    <= dev_next;
        blk_reg    <= blk_next;
        idx_reg    <= idx_next;
        rsp_reg    <= rsp_next;
    end

    assign out_valid = out_valid_reg;
    assign out_rsp   = rsp_reg;

endmodule

`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for lru_block_buffer_cache: a short table of directed requests,
// then random episodes, with every response checked against a typed-in or shadow expectation.
// Depends on lbc_pkg, lbc_req_if, lbc_rsp_if and the block's RTL.

module tb_top;

    localparam int ENTRIES      = 32;
    localparam int RESET_CYCLES = 8;
    localparam int SETTLE_CYCLES = 50;
    localparam int RANDOM_ITEMS = 450;
    localparam int MAX_REPORTS  = 40;
    localparam longint TIMEOUT_NS = 10_000_000;

    // One request of the stimulus; known rows carry the response typed in by hand.
    typedef struct {
        lbc_pkg::action_t          act;
        logic [lbc_pkg::DEV_W-1:0] dev;
        logic [lbc_pkg::BLK_W-1:0] blk;
        logic [lbc_pkg::IDX_W-1:0] idx;
        bit                        known;
        lbc_pkg::rsp_t             want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    lbc_req_if req_ch();
    lbc_rsp_if rsp_ch();

    lru_block_buffer_cache #(.ENTRIES(ENTRIES)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the cache contents and of its recency list.
    logic [lbc_pkg::DEV_W-1:0] shadow_dev    [ENTRIES];
    logic [lbc_pkg::BLK_W-1:0] shadow_blk    [ENTRIES];
    bit                        shadow_filled [ENTRIES];
    logic [lbc_pkg::CNT_W-1:0] shadow_refs   [ENTRIES];
    int                        lru_list      [ENTRIES];  // position 0 is the most recent entry

    lbc_pkg::rsp_t pending_responses[$];
    stim_row_t     directed_rows[$];

    // Small pool of tags that reads come back to, so that hits are common.
    logic [lbc_pkg::DEV_W-1:0] hot_dev [8];
    logic [lbc_pkg::BLK_W-1:0] hot_blk [8];

    int fail_count;
    int requests_sent;
    int responses_seen;
    int hit_count;
    int fill_count;
    int nofree_count;
    int under_count;
    int sat_count;
    bit calm;

    // Clock.
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Print one line for a failure and count it.
    task automatic note_failure(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    // Idle cycles for either side: mostly none or short, now and then long.
    function automatic int idle_cycles(bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 2);
        if (r < 96)
            return $urandom_range(3, 6);
        return $urandom_range(10, 40);
    endfunction

    // Random field values at their own widths.
    function automatic logic [lbc_pkg::DEV_W-1:0] rand_dev();
        return lbc_pkg::DEV_W'($urandom);
    endfunction

    function automatic logic [lbc_pkg::IDX_W-1:0] rand_idx();
        return lbc_pkg::IDX_W'($urandom);
    endfunction

    // Move an entry to the most recent place of the recency list.
    function automatic void promote(int e);
        int p;
        p = 0;
        while (p < ENTRIES && lru_list[p] != e)
            p++;
        if (p < ENTRIES)
        begin
            while (p > 0)
            begin
                lru_list[p] = lru_list[p-1];
                p--;
            end
            lru_list[0] = e;
        end
    endfunction

    // Work out the response to one request and update the shadow state.
    function automatic lbc_pkg::rsp_t predict_response(stim_row_t row);
        lbc_pkg::rsp_t r;
        int            p;
        int            e;
        bit            found;
        bit            freed;
        r = '0;
        found = 1'b0;
        freed = 1'b0;
        if (row.act == lbc_pkg::ACT_READ)
        begin
            // Look for the tag from the most recent entry on.
            for (p = 0; p < ENTRIES && !found; p++)
            begin
                e = lru_list[p];
                if (shadow_dev[e] == row.dev && shadow_blk[e] == row.blk)
                begin
                    found = 1'b1;
                    r.granted_entry = lbc_pkg::IDX_W'(e);
                    r.was_hit = 1'b1;
                    if (shadow_refs[e] == lbc_pkg::COUNT_MAX)
                        r.status = lbc_pkg::ST_SAT;
                    else
                    begin
                        shadow_refs[e]++;
                        r.fill_needed = !shadow_filled[e];
                        shadow_filled[e] = 1'b1;
                    end
                end
            end
            // On a miss, recycle the least recent entry that nobody holds.
            for (p = ENTRIES - 1; p >= 0 && !found && !freed; p--)
            begin
                e = lru_list[p];
                if (shadow_refs[e] == 0)
                begin
                    freed = 1'b1;
                    r.granted_entry = lbc_pkg::IDX_W'(e);
                    shadow_dev[e] = row.dev;
                    shadow_blk[e] = row.blk;
                    shadow_refs[e] = lbc_pkg::CNT_W'(1);
                    shadow_filled[e] = 1'b1;
                    r.fill_needed = 1'b1;
                end
            end
            if (!found && !freed)
                r.status = lbc_pkg::ST_NOFREE;
        end
        else
        begin
            r.granted_entry = row.idx;
            if (row.idx < ENTRIES)
            begin
                if (row.act == lbc_pkg::ACT_PIN)
                begin
                    if (shadow_refs[row.idx] == lbc_pkg::COUNT_MAX)
                        r.status = lbc_pkg::ST_SAT;
                    else
                        shadow_refs[row.idx]++;
                end
                else if (shadow_refs[row.idx] == 0)
                    r.status = lbc_pkg::ST_UNDER;
                else
                begin
                    shadow_refs[row.idx]--;
                    if (row.act == lbc_pkg::ACT_RELEASE && shadow_refs[row.idx] == 0)
                        promote(row.idx);
                end
            end
        end
        return r;
    endfunction

    function automatic int free_entries();
        int n;
        n = 0;
        for (int e = 0; e < ENTRIES; e++)
            if (shadow_refs[e] == 0)
                n++;
        return n;
    endfunction

    // An entry with a nonzero count, searched from a random start; random if none.
    function automatic logic [lbc_pkg::IDX_W-1:0] pick_held_entry();
        int start;
        int e;
        start = $urandom_range(0, ENTRIES - 1);
        for (int k = 0; k < ENTRIES; k++)
        begin
            e = (start + k) % ENTRIES;
            if (shadow_refs[e] != 0)
                return lbc_pkg::IDX_W'(e);
        end
        return lbc_pkg::IDX_W'(start);
    endfunction

    function automatic stim_row_t make_row(lbc_pkg::action_t act,
                                           logic [lbc_pkg::DEV_W-1:0] dev,
                                           logic [lbc_pkg::BLK_W-1:0] blk,
                                           logic [lbc_pkg::IDX_W-1:0] idx);
        stim_row_t row;
        row.act = act;
        row.dev = dev;
        row.blk = blk;
        row.idx = idx;
        row.known = 1'b0;
        row.want = '0;
        return row;
    endfunction

    function automatic void add_row(lbc_pkg::action_t act, logic [lbc_pkg::DEV_W-1:0] dev,
                                    logic [lbc_pkg::BLK_W-1:0] blk,
                                    logic [lbc_pkg::IDX_W-1:0] idx,
                                    bit known = 1'b0, int granted = 0, bit hit = 1'b0,
                                    bit fill = 1'b0,
                                    lbc_pkg::status_t st = lbc_pkg::ST_OK);
        stim_row_t row;
        row = make_row(act, dev, blk, idx);
        row.known = known;
        row.want.granted_entry = lbc_pkg::IDX_W'(granted);
        row.want.was_hit = hit;
        row.want.fill_needed = fill;
        row.want.status = st;
        directed_rows.push_back(row);
    endfunction

    // Drive one request, wait for it to be taken and queue its expected response.
    task automatic send_request(input stim_row_t row, output lbc_pkg::rsp_t pred);
        int gap;
        gap = idle_cycles(calm);
        if (gap > 0)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_ch.valid        <= 1'b1;
        req_ch.action       <= row.act;
        req_ch.device       <= row.dev;
        req_ch.block_number <= row.blk;
        req_ch.entry_index  <= row.idx;
        do
        begin
            @(posedge clk);
        end
        while (req_ch.ready !== 1'b1);
        pred = predict_response(row);
        pending_responses.push_back(row.known ? row.want : pred);
        requests_sent++;
    endtask

    // Hold off new requests until every outstanding response has come back.
    task automatic wait_drained();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_responses.size() != 0)
            @(posedge clk);
    endtask

    // Response side: ready high in bursts, with stalls of random length between.
    initial
    begin : response_ready
        int on_len;
        int off_len;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            on_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 6);
            rsp_ch.ready <= 1'b1;
            repeat (on_len) @(negedge clk);
            off_len = idle_cycles(1'b0);
            if (off_len > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (off_len) @(negedge clk);
            end
        end
    end

    // Compare each response taken with the oldest expectation.
    always @(posedge clk)
    begin : check_response
        lbc_pkg::rsp_t want;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (pending_responses.size() == 0)
                note_failure($sformatf("response with nothing outstanding: entry %0d status %0d",
                                       rsp_ch.granted_entry, rsp_ch.status));
            else
            begin
                want = pending_responses.pop_front();
                responses_seen++;
                if (rsp_ch.granted_entry !== want.granted_entry)
                    note_failure($sformatf("response %0d granted_entry %0d, expected %0d",
                                           responses_seen, rsp_ch.granted_entry,
                                           want.granted_entry));
                if (rsp_ch.was_hit !== want.was_hit)
                    note_failure($sformatf("response %0d was_hit %0b, expected %0b",
                                           responses_seen, rsp_ch.was_hit, want.was_hit));
                if (rsp_ch.fill_needed !== want.fill_needed)
                    note_failure($sformatf("response %0d fill_needed %0b, expected %0b",
                                           responses_seen, rsp_ch.fill_needed,
                                           want.fill_needed));
                if (rsp_ch.status !== want.status)
                    note_failure($sformatf("response %0d status %0d, expected %0d",
                                           responses_seen, rsp_ch.status, want.status));
                hit_count  += want.was_hit;
                fill_count += want.fill_needed;
                case (want.status)
                    lbc_pkg::ST_NOFREE: nofree_count++;
                    lbc_pkg::ST_UNDER:  under_count++;
                    lbc_pkg::ST_SAT:    sat_count++;
                    default:            ;
                endcase
            end
        end
    end

    // Run limit.
    initial
    begin : run_limit
        #(TIMEOUT_NS);
        $display("Timed out with %0d responses outstanding.", pending_responses.size());
        $display("== FAIL ==");
        $finish;
    end

    // Stimulus.
    initial
    begin : stimulus
        lbc_pkg::rsp_t             pred;
        stim_row_t                 row;
        int                        choice;
        int                        guard;
        int                        e;
        int                        start;
        int                        slot;
        logic [lbc_pkg::DEV_W-1:0] d;
        logic [lbc_pkg::BLK_W-1:0] b;
        bit                        sat_done;

        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.action = lbc_pkg::ACT_READ;
        req_ch.device = '0;
        req_ch.block_number = '0;
        req_ch.entry_index = '0;
        calm = 1'b0;
        sat_done = 1'b0;
        fail_count = 0;
        requests_sent = 0;
        responses_seen = 0;
        hit_count = 0;
        fill_count = 0;
        nofree_count = 0;
        under_count = 0;
        sat_count = 0;

        // Shadow state after reset: all tags zero, last entry most recent.
        for (int p = 0; p < ENTRIES; p++)
        begin
            shadow_dev[p] = '0;
            shadow_blk[p] = '0;
            shadow_filled[p] = 1'b0;
            shadow_refs[p] = '0;
            lru_list[p] = ENTRIES - 1 - p;
        end
        hot_dev[0] = 8'h00;
        hot_blk[0] = 32'h0000_0000;
        hot_dev[1] = 8'hFF;
        hot_blk[1] = 32'hFFFF_FFFF;
        for (int k = 2; k < 8; k++)
        begin
            hot_dev[k] = rand_dev();
            hot_blk[k] = $urandom;
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table. Zero tags after reset make the first read a hit that needs a fill.
        add_row(lbc_pkg::ACT_READ,    8'h00, 32'h0000_0000, 5'd0,
                1'b1, 31, 1'b1, 1'b1, lbc_pkg::ST_OK);
        add_row(lbc_pkg::ACT_READ,    8'h00, 32'h0000_0000, 5'd0,
                1'b1, 31, 1'b1, 1'b0, lbc_pkg::ST_OK);
        add_row(lbc_pkg::ACT_RELEASE, 8'hFF, 32'hFFFF_FFFF, 5'd31,
                1'b1, 31, 1'b0, 1'b0, lbc_pkg::ST_OK);
        add_row(lbc_pkg::ACT_RELEASE, 8'h00, 32'h0000_0000, 5'd31,
                1'b1, 31, 1'b0, 1'b0, lbc_pkg::ST_OK);
        add_row(lbc_pkg::ACT_RELEASE, 8'h00, 32'h0000_0000, 5'd31,
                1'b1, 31, 1'b0, 1'b0, lbc_pkg::ST_UNDER);
        add_row(lbc_pkg::ACT_UNPIN,   8'h00, 32'h0000_0000, 5'd0,
                1'b1, 0,  1'b0, 1'b0, lbc_pkg::ST_UNDER);
        add_row(lbc_pkg::ACT_READ,    8'hFF, 32'hFFFF_FFFF, 5'd0,
                1'b1, 0,  1'b0, 1'b1, lbc_pkg::ST_OK);
        add_row(lbc_pkg::ACT_PIN,     8'h00, 32'h0000_0000, 5'd0,
                1'b1, 0,  1'b0, 1'b0, lbc_pkg::ST_OK);
        add_row(lbc_pkg::ACT_UNPIN,   8'h00, 32'h0000_0000, 5'd0);
        add_row(lbc_pkg::ACT_READ,    8'hA5, 32'h5A5A_5A5A, 5'd10);
        add_row(lbc_pkg::ACT_READ,    8'h5A, 32'hA5A5_A5A5, 5'd21);
        add_row(lbc_pkg::ACT_RELEASE, 8'h00, 32'h0000_0000, 5'd0);
        add_row(lbc_pkg::ACT_READ,    8'hFF, 32'hFFFF_FFFF, 5'd0);
        add_row(lbc_pkg::ACT_RELEASE, 8'h00, 32'h0000_0000, 5'd0);
        add_row(lbc_pkg::ACT_READ,    8'h01, 32'h0000_0001, 5'd0);
        add_row(lbc_pkg::ACT_PIN,     8'h00, 32'h0000_0000, 5'd31);
        add_row(lbc_pkg::ACT_UNPIN,   8'h00, 32'h0000_0000, 5'd31);
        add_row(lbc_pkg::ACT_RELEASE, 8'h00, 32'h0000_0000, 5'd2);
        add_row(lbc_pkg::ACT_READ,    8'h00, 32'h0000_0000, 5'd0);
        add_row(lbc_pkg::ACT_READ,    8'hFF, 32'h0000_0000, 5'd0);
        add_row(lbc_pkg::ACT_READ,    8'h00, 32'hFFFF_FFFF, 5'd0);
        add_row(lbc_pkg::ACT_PIN,     8'h00, 32'h0000_0000, 5'd30);
        add_row(lbc_pkg::ACT_RELEASE, 8'h00, 32'h0000_0000, 5'd30);
        foreach (directed_rows[i])
            send_request(directed_rows[i], pred);

        // Let everything come back before the random part.
        wait_drained();

        // Random episodes until enough requests have gone out.
        while (requests_sent < directed_rows.size() + RANDOM_ITEMS)
        begin
            calm = ($urandom_range(0, 4) == 0);
            choice = $urandom_range(0, 99);
            if (!sat_done && requests_sent > directed_rows.size() + 120)
            begin
                // Drive one count to its ceiling, then pin and read it, unpin it and read it once more.
                d = rand_dev();
                b = $urandom;
                send_request(make_row(lbc_pkg::ACT_READ, d, b, rand_idx()), pred);
                e = (pred.status == lbc_pkg::ST_NOFREE) ? $urandom_range(0, ENTRIES - 1)
                                                        : pred.granted_entry;
                while (shadow_refs[e] != lbc_pkg::COUNT_MAX)
                    send_request(make_row(lbc_pkg::ACT_PIN, rand_dev(), $urandom,
                                          lbc_pkg::IDX_W'(e)), pred);
                send_request(make_row(lbc_pkg::ACT_PIN, rand_dev(), $urandom,
                                      lbc_pkg::IDX_W'(e)), pred);
                send_request(make_row(lbc_pkg::ACT_READ, shadow_dev[e], shadow_blk[e], '0),
                             pred);
                send_request(make_row(lbc_pkg::ACT_UNPIN, '0, '0, lbc_pkg::IDX_W'(e)), pred);
                send_request(make_row(lbc_pkg::ACT_READ, shadow_dev[e], shadow_blk[e], '0),
                             pred);
                sat_done = 1'b1;
            end
            else if (choice < 15)
            begin
                // Hold every entry, get refused, then give the low counts back.
                guard = 0;
                while (free_entries() > 0 && guard < 40)
                begin
                    send_request(make_row(lbc_pkg::ACT_READ, rand_dev(), $urandom,
                                          rand_idx()), pred);
                    guard++;
                end
                repeat (2)
                    send_request(make_row(lbc_pkg::ACT_READ, rand_dev(), $urandom,
                                          rand_idx()), pred);
                slot = $urandom_range(0, 7);
                send_request(make_row(lbc_pkg::ACT_READ, hot_dev[slot], hot_blk[slot], '0),
                             pred);
                start = $urandom_range(0, ENTRIES - 1);
                for (int k = 0; k < ENTRIES; k++)
                begin
                    e = (start + k) % ENTRIES;
                    while (shadow_refs[e] != 0 && shadow_refs[e] <= 16)
                        send_request(make_row(lbc_pkg::ACT_RELEASE, rand_dev(), $urandom,
                                              lbc_pkg::IDX_W'(e)), pred);
                end
            end
            else
            begin
                if (choice < 25)
                    wait_drained();
                repeat ($urandom_range(8, 30))
                begin
                    choice = $urandom_range(0, 99);
                    if (choice < 40)
                    begin
                        // Reads mostly come back to known tags.
                        slot = $urandom_range(0, 7);
                        if ($urandom_range(0, 15) == 0)
                        begin
                            hot_dev[slot] = rand_dev();
                            hot_blk[slot] = $urandom;
                        end
                        if ($urandom_range(0, 9) < 7)
                        begin
                            d = hot_dev[slot];
                            b = hot_blk[slot];
                        end
                        else
                        begin
                            d = rand_dev();
                            b = $urandom;
                        end
                        row = make_row(lbc_pkg::ACT_READ, d, b, rand_idx());
                    end
                    else if (choice < 70)
                        row = make_row(lbc_pkg::ACT_RELEASE, rand_dev(), $urandom,
                                       pick_held_entry());
                    else if (choice < 80)
                        row = make_row(lbc_pkg::ACT_PIN, rand_dev(), $urandom,
                                       $urandom_range(0, 1) ? pick_held_entry() : rand_idx());
                    else if (choice < 95)
                        row = make_row(lbc_pkg::ACT_UNPIN, rand_dev(), $urandom,
                                       pick_held_entry());
                    else
                        row = make_row(lbc_pkg::action_t'($urandom_range(0, 3)), rand_dev(),
                                       $urandom, rand_idx());
                    send_request(row, pred);
                end
            end
        end

        // Wait for the last responses, then watch for strays.
        calm = 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d requests and checked %0d responses: %0d hits, %0d fills.",
                 requests_sent, responses_seen, hit_count, fill_count);
        $display("Errors seen: %0d no free entry, %0d underflows, %0d saturated counts.",
                 nofree_count, under_count, sat_count);
        if (pending_responses.size() != 0)
            note_failure($sformatf("%0d responses never arrived", pending_responses.size()));
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: files.f
rtl/core/lbc_pkg.sv
rtl/core/lbc_req_if.sv
rtl/core/lbc_rsp_if.sv
rtl/core/lbc_cell.sv
rtl/core/lbc_ctrl.sv
rtl/core/lru_block_buffer_cache.sv
verif/tb_top.sv
